// ===== sv/rclp_pkg.sv =====
// ============================================================================
// rclp_pkg - shared types and constants of the robot command line parser
// Field widths, command codes, the command keyword table and factor resets.
// ============================================================================
`default_nettype none

package rclp_pkg;

    localparam int AXIS_COUNT  = 6;
    localparam int ANGLE_LIMIT = 1000000;

    localparam int FACTOR_REGS = 6;
    localparam int FACTOR_W    = 16;
    localparam int ACC_W       = $clog2(ANGLE_LIMIT + 1);
    localparam int ANGLE_W     = ACC_W + 1;
    localparam int MUL_W       = ACC_W + 4;
    localparam int COUNT_W     = $clog2(AXIS_COUNT + 2);
    localparam int PULSE_W     = 37;
    localparam int CFG_IDX_W   = 3;
    localparam int PREFIX_MAX  = 6;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET [FACTOR_REGS] =
        '{16'd1435, 16'd1300, 16'd1377, 16'd996, 16'd824, 16'd350};

    typedef enum logic [2:0] {
        KIND_SRVON  = 3'd0,
        KIND_SRVOFF = 3'd1,
        KIND_EXIT   = 3'd2,
        KIND_MOVE   = 3'd3,
        KIND_BAD    = 3'd4
    } kind_t;

    typedef logic signed [ANGLE_W-1:0] angle_t;

    // Everything the result stage needs once a message has ended.
    typedef struct packed {
        kind_t                         kind;
        logic [AXIS_COUNT-1:0][ANGLE_W-1:0] angle;
    } finish_t;

    // Keyword characters: row 0 SRVON, row 1 SRVOFF, row 2 EXIT.
    function automatic logic [7:0] cmd_char(input logic [1:0] k, input logic [2:0] pos);
        logic [PREFIX_MAX-1:0][7:0] row;
        unique case (k)
            2'd0:    row = {8'h00, "N", "O", "V", "R", "S"};
            2'd1:    row = {"F", "F", "O", "V", "R", "S"};
            2'd2:    row = {8'h00, 8'h00, "T", "I", "X", "E"};
            default: row = '0;
        endcase
        unique case (pos)
            3'd0:    return row[0];
            3'd1:    return row[1];
            3'd2:    return row[2];
            3'd3:    return row[3];
            3'd4:    return row[4];
            3'd5:    return row[5];
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [2:0] cmd_len(input logic [1:0] k);
        unique case (k)
            2'd0:    return 3'd5;
            2'd1:    return 3'd6;
            2'd2:    return 3'd4;
            default: return 3'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== sv/rclp_parser.sv =====
// ============================================================================
// rclp_parser - per-byte message parser
// Tracks the command prefix and splits the text into atoi-style tokens. The
// finish output gives the classified result as it stands after this beat.
// ============================================================================
`default_nettype none

module rclp_parser (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            byte_accept,
    input  wire logic [7:0]      text_byte,
    input  wire logic            message_end,
    output rclp_pkg::finish_t    finish
);

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    logic [2:0]                       prefix_pos_reg,   prefix_pos_next;
    logic [2:0]                       prefix_match_reg, prefix_match_next;
    logic                             text_ended_reg,   text_ended_next;
    logic                             inside_reg,       inside_next;
    phase_t                           phase_reg,        phase_next;
    logic                             neg_reg,          neg_next;
    logic [rclp_pkg::ACC_W-1:0]       acc_reg,          acc_next;
    logic [rclp_pkg::COUNT_W-1:0]     count_reg,        count_next;
    rclp_pkg::angle_t                 angle_reg [rclp_pkg::AXIS_COUNT];
    rclp_pkg::angle_t                 angle_next [rclp_pkg::AXIS_COUNT];

    function automatic rclp_pkg::angle_t signed_angle(
        input logic neg, input logic [rclp_pkg::ACC_W-1:0] acc);
        rclp_pkg::angle_t mag;
        mag = rclp_pkg::angle_t'({1'b0, acc});
        return neg ? -mag : mag;
    endfunction

    always_comb begin
        logic                          is_space;
        logic                          is_digit;
        logic [rclp_pkg::MUL_W-1:0]    acc_wide;
        logic                          fin_inside;
        logic [rclp_pkg::COUNT_W-1:0]  fin_count;
        rclp_pkg::angle_t              fin_angle [rclp_pkg::AXIS_COUNT];

        prefix_pos_next   = prefix_pos_reg;
        prefix_match_next = prefix_match_reg;
        text_ended_next   = text_ended_reg;
        inside_next       = inside_reg;
        phase_next        = phase_reg;
        neg_next          = neg_reg;
        acc_next          = acc_reg;
        count_next        = count_reg;
        angle_next        = angle_reg;

        is_space = (text_byte == 8'h20) || (text_byte >= 8'h09 && text_byte <= 8'h0D);
        is_digit = (text_byte >= "0") && (text_byte <= "9");
        acc_wide = rclp_pkg::MUL_W'(acc_reg) * rclp_pkg::MUL_W'(10)
                 + rclp_pkg::MUL_W'(text_byte[3:0]);

        if (!text_ended_reg) begin
            if (prefix_pos_reg < 3'(rclp_pkg::PREFIX_MAX)) begin
                for (int k = 0; k < 3; k++) begin
                    if (prefix_pos_reg < rclp_pkg::cmd_len(2'(k)) &&
                        text_byte != rclp_pkg::cmd_char(2'(k), prefix_pos_reg)) begin
                        prefix_match_next[k] = 1'b0;
                    end
                end
                prefix_pos_next = prefix_pos_reg + 3'd1;
            end

            if (text_byte == 8'h00 || text_byte == "," || text_byte == " ") begin
                if (inside_reg) begin
                    if (count_reg < rclp_pkg::COUNT_W'(rclp_pkg::AXIS_COUNT)) begin
                        angle_next[count_reg[rclp_pkg::COUNT_W-1:0]] =
                            signed_angle(neg_reg, acc_reg);
                    end
                    if (count_reg <= rclp_pkg::COUNT_W'(rclp_pkg::AXIS_COUNT)) begin
                        count_next = count_reg + 1'b1;
                    end
                    inside_next = 1'b0;
                end
                if (text_byte == 8'h00) begin
                    text_ended_next = 1'b1;
                end
            end else begin
                // A fresh token starts from a cleared number.
                if (!inside_reg) begin
                    inside_next = 1'b1;
                    phase_next  = PH_SKIP;
                    neg_next    = 1'b0;
                    acc_next    = '0;
                    acc_wide    = rclp_pkg::MUL_W'(text_byte[3:0]);
                end
                unique case (phase_next)
                    PH_SKIP: begin
                        if (is_space) begin
                            phase_next = PH_SKIP;
                        end else if (text_byte == "-" || text_byte == "+") begin
                            neg_next   = (text_byte == "-");
                            phase_next = PH_DIGITS;
                        end else if (is_digit) begin
                            phase_next = PH_DIGITS;
                            acc_next   = (acc_wide > rclp_pkg::MUL_W'(rclp_pkg::ANGLE_LIMIT))
                                       ? rclp_pkg::ACC_W'(rclp_pkg::ANGLE_LIMIT)
                                       : acc_wide[rclp_pkg::ACC_W-1:0];
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DIGITS: begin
                        if (is_digit) begin
                            acc_next = (acc_wide > rclp_pkg::MUL_W'(rclp_pkg::ANGLE_LIMIT))
                                     ? rclp_pkg::ACC_W'(rclp_pkg::ANGLE_LIMIT)
                                     : acc_wide[rclp_pkg::ACC_W-1:0];
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DONE: begin
                        phase_next = PH_DONE;
                    end
                    default: begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end

        // The final beat closes any open token before the result is judged.
        fin_inside = inside_next;
        fin_count  = count_next;
        fin_angle  = angle_next;
        if (fin_inside) begin
            if (fin_count < rclp_pkg::COUNT_W'(rclp_pkg::AXIS_COUNT)) begin
                fin_angle[fin_count[rclp_pkg::COUNT_W-1:0]] = signed_angle(neg_next, acc_next);
            end
            if (fin_count <= rclp_pkg::COUNT_W'(rclp_pkg::AXIS_COUNT)) begin
                fin_count = fin_count + 1'b1;
            end
        end

        if (prefix_match_next[0] && prefix_pos_next >= rclp_pkg::cmd_len(2'd0)) begin
            finish.kind = rclp_pkg::KIND_SRVON;
        end else if (prefix_match_next[1] && prefix_pos_next >= rclp_pkg::cmd_len(2'd1)) begin
            finish.kind = rclp_pkg::KIND_SRVOFF;
        end else if (prefix_match_next[2] && prefix_pos_next >= rclp_pkg::cmd_len(2'd2)) begin
            finish.kind = rclp_pkg::KIND_EXIT;
        end else if (fin_count == rclp_pkg::COUNT_W'(rclp_pkg::AXIS_COUNT)) begin
            finish.kind = rclp_pkg::KIND_MOVE;
        end else begin
            finish.kind = rclp_pkg::KIND_BAD;
        end
        for (int j = 0; j < rclp_pkg::AXIS_COUNT; j++) begin
            finish.angle[j] = fin_angle[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_accept && message_end)) begin
            prefix_pos_reg   <= '0;
            prefix_match_reg <= 3'b111;
            text_ended_reg   <= 1'b0;
            inside_reg       <= 1'b0;
            phase_reg        <= PH_SKIP;
            neg_reg          <= 1'b0;
            acc_reg          <= '0;
            count_reg        <= '0;
            for (int j = 0; j < rclp_pkg::AXIS_COUNT; j++) begin
                angle_reg[j] <= '0;
            end
        end else if (byte_accept) begin
            prefix_pos_reg   <= prefix_pos_next;
            prefix_match_reg <= prefix_match_next;
            text_ended_reg   <= text_ended_next;
            inside_reg       <= inside_next;
            phase_reg        <= phase_next;
            neg_reg          <= neg_next;
            acc_reg          <= acc_next;
            count_reg        <= count_next;
            angle_reg        <= angle_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/robot_command_line_parser_core.sv =====
// ============================================================================
// robot_command_line_parser_core - ASCII robot command classifier
// Takes one message byte per beat and returns one classified result per message.
// ============================================================================
// The block accepts one text byte on every clock cycle with no gaps between
// messages as long as results are taken. The input stalls only while a captured
// result waits behind a result beat that m_ready has not yet taken. Each
// message yields one result beat: the parsed angles and command kind are
// captured into a snapshot register, and the six angles are multiplied by
// their factors into the output register. Command keywords SRVON, SRVOFF and
// EXIT take priority over the move form; a move needs exactly six comma or
// space separated tokens, otherwise the kind is a bad token count.
// The factor registers should be written only while no message is in flight.
`default_nettype none

module robot_command_line_parser_core (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,

    input  wire logic                                  cfg_valid,
    output      logic                                  cfg_ready,
    input  wire logic [rclp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [rclp_pkg::FACTOR_W-1:0]         cfg_data,

    input  wire logic                                  s_valid,
    output      logic                                  s_ready,
    input  wire logic [7:0]                            s_text_byte,
    input  wire logic                                  s_message_end,

    output      logic                                  m_valid,
    input  wire logic                                  m_ready,
    output      logic [2:0]                            m_command_kind,
    output      logic signed [rclp_pkg::PULSE_W-1:0]   m_pulse_axis_0,
    output      logic signed [rclp_pkg::PULSE_W-1:0]   m_pulse_axis_1,
    output      logic signed [rclp_pkg::PULSE_W-1:0]   m_pulse_axis_2,
    output      logic signed [rclp_pkg::PULSE_W-1:0]   m_pulse_axis_3,
    output      logic signed [rclp_pkg::PULSE_W-1:0]   m_pulse_axis_4,
    output      logic signed [rclp_pkg::PULSE_W-1:0]   m_pulse_axis_5
);

    logic [rclp_pkg::FACTOR_W-1:0]        factor_reg [rclp_pkg::FACTOR_REGS];
    rclp_pkg::finish_t                    finish;
    rclp_pkg::finish_t                    snap_reg;
    logic                                 snap_valid_reg;
    logic                                 out_valid_reg;
    rclp_pkg::kind_t                      kind_reg;
    logic [rclp_pkg::PULSE_W-1:0]         pulse_reg  [rclp_pkg::FACTOR_REGS];
    logic [rclp_pkg::PULSE_W-1:0]         pulse_next [rclp_pkg::FACTOR_REGS];
    logic                                 advance;
    logic                                 in_accept;

    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = !snap_valid_reg || advance;
    assign in_accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    rclp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (in_accept),
        .text_byte   (s_text_byte),
        .message_end (s_message_end),
        .finish      (finish)
    );

    always_comb begin
        logic signed [rclp_pkg::PULSE_W:0] prod;
        for (int j = 0; j < rclp_pkg::FACTOR_REGS; j++) begin
            pulse_next[j] = '0;
            if (j < rclp_pkg::AXIS_COUNT) begin
                prod = $signed(snap_reg.angle[j]) * $signed({1'b0, factor_reg[j]});
                if (snap_reg.kind == rclp_pkg::KIND_MOVE) begin
                    pulse_next[j] = prod[rclp_pkg::PULSE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int j = 0; j < rclp_pkg::FACTOR_REGS; j++) begin
                factor_reg[j] <= rclp_pkg::FACTOR_RESET[j];
            end
        end else begin
            if (cfg_valid && cfg_index < rclp_pkg::CFG_IDX_W'(rclp_pkg::FACTOR_REGS)) begin
                factor_reg[cfg_index] <= cfg_data;
            end
            if (advance) begin
                out_valid_reg <= snap_valid_reg;
                if (snap_valid_reg) begin
                    kind_reg  <= snap_reg.kind;
                    pulse_reg <= pulse_next;
                end
            end
            if (in_accept && s_message_end) begin
                snap_valid_reg <= 1'b1;
                snap_reg       <= finish;
            end else if (advance) begin
                snap_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_command_kind = kind_reg;
    assign m_pulse_axis_0 = pulse_reg[0];
    assign m_pulse_axis_1 = pulse_reg[1];
    assign m_pulse_axis_2 = pulse_reg[2];
    assign m_pulse_axis_3 = pulse_reg[3];
    assign m_pulse_axis_4 = pulse_reg[4];
    assign m_pulse_axis_5 = pulse_reg[5];

`ifndef SYNTHESIS
    a_pulse_zero_off_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_command_kind != rclp_pkg::KIND_MOVE) |->
        (m_pulse_axis_0 == '0 && m_pulse_axis_1 == '0 && m_pulse_axis_2 == '0 &&
         m_pulse_axis_3 == '0 && m_pulse_axis_4 == '0 && m_pulse_axis_5 == '0))
        else $error("pulse field set on a result that is not a move");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (snap_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled while the pipeline has room");

    a_snap_moves_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (snap_valid_reg && advance) |=>
        (m_valid && m_command_kind == $past(snap_reg.kind)))
        else $error("captured result did not reach the output register");

    a_kind_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_command_kind <= rclp_pkg::KIND_BAD))
        else $error("command kind out of range");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ============================================================================
// tb - self-checking testbench of robot_command_line_parser_core
// Messages of ASCII bytes go in over a valid/ready stream with random gaps.
// An in-bench parser predicts one reply per message, and every reply beat is
// checked field by field. The factor registers are reprogrammed between phases.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rclp_pkg::*;

    localparam int PULSE_PORTS       = 6;
    localparam int REG_FACTOR_AXIS_0 = 0;
    localparam int LONG_HOLD         = 300;
    localparam int PHASE_BYTES       = 140;

    typedef struct packed {
        logic [7:0] text;
        logic       last;
    } text_beat_t;

    typedef struct packed {
        kind_t                                 kind;
        logic [PULSE_PORTS-1:0][PULSE_W-1:0]   pulse;
    } reply_t;

    typedef enum logic [1:0] {
        SKIP_SPACE,
        READ_DIGITS,
        TOKEN_DONE
    } digit_phase_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [FACTOR_W-1:0]   cfg_data  = '0;

    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_text_byte   = 8'h00;
    logic        s_message_end = 1'b0;

    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [2:0]                 m_command_kind;
    logic signed [PULSE_W-1:0]  m_pulse_axis_0;
    logic signed [PULSE_W-1:0]  m_pulse_axis_1;
    logic signed [PULSE_W-1:0]  m_pulse_axis_2;
    logic signed [PULSE_W-1:0]  m_pulse_axis_3;
    logic signed [PULSE_W-1:0]  m_pulse_axis_4;
    logic signed [PULSE_W-1:0]  m_pulse_axis_5;

    robot_command_line_parser_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_message_end (s_message_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_command_kind(m_command_kind),
        .m_pulse_axis_0(m_pulse_axis_0),
        .m_pulse_axis_1(m_pulse_axis_1),
        .m_pulse_axis_2(m_pulse_axis_2),
        .m_pulse_axis_3(m_pulse_axis_3),
        .m_pulse_axis_4(m_pulse_axis_4),
        .m_pulse_axis_5(m_pulse_axis_5)
    );

    always #1 aclk = ~aclk;

    // Parser state of the prediction, mirrored per accepted byte.
    string        keyword      [3] = '{"SRVON", "SRVOFF", "EXIT"};
    kind_t        keyword_kind [3] = '{KIND_SRVON, KIND_SRVOFF, KIND_EXIT};
    logic [FACTOR_W-1:0] factor [FACTOR_REGS] = FACTOR_RESET;
    int           kw_pos;
    logic [2:0]   kw_alive;
    bit           text_done;
    bit           in_token;
    bit           num_neg;
    digit_phase_t num_phase;
    int unsigned  digits;
    int           tokens;
    int           angle [AXIS_COUNT];

    text_beat_t   byte_backlog [$];
    reply_t       pending_replies [$];
    logic [7:0]   msg_buf [$];
    int           queued_bytes;
    int           mismatches;
    bit           no_idle;

    function automatic void clear_parse();
        kw_pos    = 0;
        kw_alive  = 3'b111;
        text_done = 1'b0;
        in_token  = 1'b0;
        num_phase = SKIP_SPACE;
        num_neg   = 1'b0;
        digits    = 0;
        tokens    = 0;
        foreach (angle[a]) angle[a] = 0;
    endfunction

    function automatic void close_token();
        if (tokens < AXIS_COUNT) angle[tokens] = num_neg ? -int'(digits) : int'(digits);
        if (tokens <= AXIS_COUNT) tokens++;
        in_token = 1'b0;
    endfunction

    // atoi-like reading of one token byte.
    function automatic void feed_token(logic [7:0] b);
        bit          ws;
        bit          dig;
        int unsigned next;
        ws  = (b == " ") || (b >= 8'h09 && b <= 8'h0D);
        dig = (b >= "0") && (b <= "9");
        if (num_phase == SKIP_SPACE) begin
            if (ws) return;
            if (b == "-" || b == "+") begin
                num_neg   = (b == "-");
                num_phase = READ_DIGITS;
                return;
            end
            num_phase = dig ? READ_DIGITS : TOKEN_DONE;
            if (!dig) return;
        end
        if (num_phase == READ_DIGITS) begin
            if (dig) begin
                next   = digits * 10 + (b - "0");
                digits = (next > ANGLE_LIMIT) ? ANGLE_LIMIT : next;
            end else begin
                num_phase = TOKEN_DONE;
            end
        end
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic last);
        reply_t r;
        kind_t  kind;
        longint prod;
        if (!text_done) begin
            if (kw_pos < 6) begin
                for (int k = 0; k < 3; k++)
                    if (kw_pos < keyword[k].len() && b != keyword[k][kw_pos]) kw_alive[k] = 1'b0;
                kw_pos++;
            end
            if (b == 8'h00) begin
                if (in_token) close_token();
                text_done = 1'b1;
            end else if (b == "," || b == " ") begin
                if (in_token) close_token();
            end else begin
                if (!in_token) begin
                    in_token  = 1'b1;
                    num_phase = SKIP_SPACE;
                    num_neg   = 1'b0;
                    digits    = 0;
                end
                feed_token(b);
            end
        end
        if (!last) return;
        if (in_token) close_token();
        // The earliest keyword in the list wins when several match.
        kind = KIND_BAD;
        for (int k = 2; k >= 0; k--)
            if (kw_alive[k] && kw_pos >= keyword[k].len()) kind = keyword_kind[k];
        if (kind == KIND_BAD && tokens == AXIS_COUNT) kind = KIND_MOVE;
        r.kind  = kind;
        r.pulse = '0;
        if (kind == KIND_MOVE) begin
            for (int a = 0; a < PULSE_PORTS && a < AXIS_COUNT; a++) begin
                prod       = longint'(angle[a]) * longint'(factor[a]);
                r.pulse[a] = prod[PULSE_W-1:0];
            end
        end
        pending_replies.push_back(r);
        clear_parse();
    endfunction

    function automatic int pick_gap(bit calm);
        int roll;
        if (calm) return 0;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Sender: one byte beat at a time from the backlog.
    text_beat_t next_beat;
    int         send_gap;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
            clear_parse();
        end else begin
            if (s_valid && s_ready) parse_byte(s_text_byte, s_message_end);
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (byte_backlog.size() > 0) begin
                    next_beat = byte_backlog.pop_front();
                    s_text_byte   <= next_beat.text;
                    s_message_end <= next_beat.last;
                    s_valid       <= 1'b1;
                    send_gap = pick_gap(no_idle);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks reply beats and stalls at random.
    reply_t                               want;
    logic [PULSE_PORTS-1:0][PULSE_W-1:0]  seen_pulse;
    int                                   stall_left;
    int                                   replies_seen;
    int                                   next_hold_at = 20;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_replies.size() == 0) begin
                    $error("reply beat arrived with no reply pending");
                    mismatches++;
                end else begin
                    want = pending_replies.pop_front();
                    if (m_command_kind !== want.kind) begin
                        $error("command_kind: expected %0d, got %0d", want.kind, m_command_kind);
                        mismatches++;
                    end
                    seen_pulse = {m_pulse_axis_5, m_pulse_axis_4, m_pulse_axis_3,
                                  m_pulse_axis_2, m_pulse_axis_1, m_pulse_axis_0};
                    for (int a = 0; a < PULSE_PORTS; a++) begin
                        if (seen_pulse[a] !== want.pulse[a]) begin
                            $error("pulse_axis_%0d: expected %0d, got %0d", a,
                                   $signed(want.pulse[a]), $signed(seen_pulse[a]));
                            mismatches++;
                        end
                    end
                end
                replies_seen++;
                // Now and then hold off long enough for the input to back up.
                if (replies_seen == next_hold_at) begin
                    stall_left   = LONG_HOLD;
                    next_hold_at = next_hold_at + 25;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall_left = pick_gap(no_idle);
            end
        end
    end

    function automatic void add_byte(logic [7:0] b);
        msg_buf.push_back(b);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) msg_buf.push_back(s[i]);
    endfunction

    function automatic void end_message();
        text_beat_t beat_out;
        foreach (msg_buf[i]) begin
            beat_out.text = msg_buf[i];
            beat_out.last = (i == msg_buf.size() - 1);
            byte_backlog.push_back(beat_out);
        end
        queued_bytes += msg_buf.size();
        msg_buf.delete();
    endfunction

    function automatic void add_sep();
        int n;
        n = $urandom_range(3, 1);
        repeat (n) add_byte($urandom_range(1) ? "," : " ");
    endfunction

    function automatic void add_junk();
        int n;
        n = $urandom_range(8, 1);
        repeat (n) add_byte(8'($urandom_range(255)));
    endfunction

    function automatic void add_number();
        int         n;
        logic [7:0] tail;
        if ($urandom_range(9) == 0) add_byte(8'($urandom_range(13, 9)));
        case ($urandom_range(3))
            0:       add_byte("-");
            1:       add_byte("+");
            default: ;
        endcase
        n = ($urandom_range(9) == 0) ? $urandom_range(10, 6) : $urandom_range(3, 1);
        repeat (n) add_byte(8'("0" + $urandom_range(9)));
        if ($urandom_range(7) == 0) begin
            tail = 8'($urandom_range(126, 33));
            add_byte((tail == ",") ? ";" : tail);
        end
    endfunction

    function automatic void random_message();
        int shape;
        int k;
        int n;
        shape = $urandom_range(99);
        if (shape < 12) begin
            k = $urandom_range(2);
            if ($urandom_range(3) == 0) add_text(keyword[k].substr(0, keyword[k].len() - 2));
            else add_text(keyword[k]);
            if ($urandom_range(1)) add_junk();
        end else if (shape < 20) begin
            add_junk();
        end else begin
            n = (shape < 70) ? AXIS_COUNT : $urandom_range(AXIS_COUNT + 3);
            if ($urandom_range(4) == 0) add_sep();
            for (int i = 0; i < n; i++) begin
                add_number();
                if (i < n - 1) add_sep();
            end
            if ($urandom_range(4) == 0) add_sep();
            if (shape >= 92) begin
                add_byte(8'h00);
                add_junk();
            end
            if (msg_buf.size() == 0) add_sep();
        end
        end_message();
    endfunction

    task automatic wait_drained();
        do @(posedge aclk);
        while (byte_backlog.size() != 0 || s_valid || pending_replies.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        logic [FACTOR_W-1:0] value;
        int                  target;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed messages under the reset factors.
        add_text("SRVON");  end_message();
        add_text("SRVOFF"); end_message();
        add_text("EXIT");   end_message();
        add_text("SRVONX,1"); end_message();
        add_text("EXIT 1,2,3,4,5,6"); end_message();
        add_text("SRVO"); end_message();
        add_text("EXI"); add_byte(8'h00); add_text("T"); end_message();
        add_text("1,2,3,4,5,6"); end_message();
        add_text("-1000000 +999999,,  12 -0 7x 99999999"); end_message();
        add_byte(8'h09); add_byte(8'h0A); add_text("-5, ");
        add_byte(8'h0B); add_byte(8'h0C); add_byte(8'h0D);
        add_text("+6,7"); add_byte(8'h09); add_text("8,9-3,10,-2"); end_message();
        add_text("1,2,3,4,5"); end_message();
        add_text("1 2 3 4 5 6 7 8 9 10"); end_message();
        add_text("1,2,3,4,5,6"); add_byte(8'h00); add_text(",7,8"); end_message();
        add_byte(8'h00); end_message();
        add_byte(8'hFF); end_message();
        add_text("a,b,c,d,e,f"); end_message();
        add_text(",,1,2,3,4,5,6,,"); end_message();
        add_text("999999,-999999,1000000,-1000000,1000001,-4294967296"); end_message();
        wait_drained();

        // Random phases, each under its own factor setting.
        for (int phase = 0; phase < 4; phase++) begin
            for (int r = 0; r < FACTOR_REGS; r++) begin
                case (phase)
                    0:       value = '1;
                    1:       value = '0;
                    2:       value = FACTOR_W'($urandom);
                    default: value = $urandom_range(1) ? FACTOR_W'(1) : FACTOR_W'($urandom);
                endcase
                cfg_index <= CFG_IDX_W'(REG_FACTOR_AXIS_0 + r);
                cfg_data  <= value;
                cfg_valid <= 1'b1;
                do @(posedge aclk); while (!cfg_ready);
                factor[r] = value;
            end
            cfg_valid <= 1'b0;
            no_idle = (phase == 2);
            target  = queued_bytes + PHASE_BYTES;
            while (queued_bytes < target) random_message();
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== robot_command_line_parser_core.f =====
sv/rclp_pkg.sv
sv/rclp_parser.sv
sv/robot_command_line_parser_core.sv
test/tb.sv
